/* hw/rtl/rlsw_pkg.sv */
// rlsw_pkg: shared constants, codes and beat types of the radial lut spectral weight block
// used by rlsw_pos, rlsw_wgt and radial_lut_spectral_weight; depends on nothing
package rlsw_pkg;

  // sizing of the design
  localparam int TableEntries = 4096;
  localparam int MaxAxis      = 1024;
  localparam int SampleWidth  = 32;

  // fixed field widths
  localparam int SizeW   = 11;
  localparam int IdxW    = 10;
  localparam int CoefW   = 40;
  localparam int TidxW   = 13;
  localparam int WgtW    = 20;
  localparam int PartW   = 32;
  localparam int Axes    = 3;

  // position arithmetic
  localparam int SqW       = 2 * IdxW;
  localparam int HalfW     = CoefW / 2;
  localparam int PartProdW = HalfW + SqW;
  localparam int ProdW     = CoefW + SqW;
  localparam int FracBits  = 32;
  localparam int TiW       = $clog2(TableEntries);
  localparam int CapW      = FracBits + TiW + 1;
  localparam int PosW      = CapW + 2;
  localparam int IntW      = PosW - FracBits;
  localparam logic [ProdW-1:0] CapLim = ProdW'(TableEntries) << FracBits;

  // interpolation
  localparam int FracW     = 17;
  localparam int FracOne   = 65536;
  localparam int RoundHalf = 32768;

  // weight table split into even and odd entries
  localparam int EvenDepth = TableEntries / 2 + 1;
  localparam int OddDepth  = (TableEntries + 1) / 2;
  localparam int EvenAw    = $clog2(EvenDepth);
  localparam int OddAw     = $clog2(OddDepth);

  // output saturation
  localparam int SatBits = (SampleWidth < 32) ? SampleWidth : 32;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_Z = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_X = 3'd2,
    CFG_COEF_Z = 3'd3,
    CFG_COEF_Y = 3'd4,
    CFG_COEF_X = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_WEIGH = 1'b1
  } op_e;

  typedef struct packed {
    logic [SizeW-1:0] size_z;
    logic [SizeW-1:0] size_y;
    logic [SizeW-1:0] size_x;
    logic [CoefW-1:0] coef_z;
    logic [CoefW-1:0] coef_y;
    logic [CoefW-1:0] coef_x;
  } cfg_t;

  // beat from the position pipe to the weighting pipe
  typedef struct packed {
    logic                    valid;
    logic                    op;
    logic [TidxW-1:0]        tidx;
    logic [WgtW-1:0]         twgt;
    logic [PosW-1:0]         pos;
    logic signed [PartW-1:0] re;
    logic signed [PartW-1:0] im;
  } pos_beat_t;

endpackage

/* hw/rtl/rlsw_ram.sv */
// rlsw_ram: generic single write port ram with one registered read port
// no package dependency
module rlsw_ram #(
  parameter int Width = 20,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rlsw_pos.sv */
// rlsw_pos: five stage pipe that folds bin indices and forms the fixed-point table position
// depends on rlsw_pkg
module rlsw_pos (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rlsw_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [rlsw_pkg::TidxW-1:0] table_index_i,
  input  logic [rlsw_pkg::WgtW-1:0]  table_weight_i,
  input  logic [rlsw_pkg::IdxW-1:0]  z_index_i,
  input  logic [rlsw_pkg::IdxW-1:0]  y_index_i,
  input  logic [rlsw_pkg::IdxW-1:0]  x_index_i,
  input  logic [rlsw_pkg::PartW-1:0] bin_real_i,
  input  logic [rlsw_pkg::PartW-1:0] bin_imag_i,
  output rlsw_pkg::pos_beat_t        beat_o,
  input  logic                       take_i
);
  import rlsw_pkg::*;

  // side payload carried along every stage
  typedef struct packed {
    logic                    op;
    logic [TidxW-1:0]        tidx;
    logic [WgtW-1:0]         twgt;
    logic signed [PartW-1:0] re;
    logic signed [PartW-1:0] im;
  } carry_t;

  // fold an index above half the axis size to its signed frequency magnitude
  function automatic logic [IdxW-1:0] fold(logic [IdxW-1:0] i, logic [SizeW-1:0] size);
    logic [SizeW-1:0] n;
    logic [SizeW-1:0] iw;
    logic [SizeW-1:0] m;
    n  = (size > SizeW'(MaxAxis)) ? SizeW'(MaxAxis) : size;
    iw = SizeW'(i);
    if (iw > (n >> 1)) begin
      m = (iw >= n) ? iw - n : n - iw;
    end else begin
      m = iw;
    end
    return m[IdxW-1:0];
  endfunction

  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;
  logic en_a, en_b, en_c, en_d, en_e;
  carry_t c_a_q, c_b_q, c_c_q, c_d_q, c_e_q, c_in;

  logic [Axes-1:0][IdxW-1:0]      m_a_d, m_a_q;
  logic [Axes-1:0][SqW-1:0]       sq_b_d, sq_b_q;
  logic [Axes-1:0][PartProdW-1:0] plo_c_d, plo_c_q, phi_c_d, phi_c_q;
  logic [Axes-1:0][CapW-1:0]      term_d_d, term_d_q;
  logic [PosW-1:0]                pos_e_d, pos_e_q;
  logic [Axes-1:0][CoefW-1:0]     coef;
  logic [Axes-1:0][ProdW-1:0]     full;

  // stage enables, from the far end back
  assign en_e = !v_e_q || take_i;
  assign en_d = !v_d_q || en_e;
  assign en_c = !v_c_q || en_d;
  assign en_b = !v_b_q || en_c;
  assign en_a = !v_a_q || en_b;
  assign in_stall_o = !en_a;

  assign c_in = '{op: operation_i, tidx: table_index_i, twgt: table_weight_i,
                  re: bin_real_i, im: bin_imag_i};
  assign coef = {cfg_i.coef_x, cfg_i.coef_y, cfg_i.coef_z};

  // stage a: fold z and y, x passes unfolded
  always_comb begin
    m_a_d[0] = fold(z_index_i, cfg_i.size_z);
    m_a_d[1] = fold(y_index_i, cfg_i.size_y);
    m_a_d[2] = x_index_i;
  end

  // stage b: squares
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      sq_b_d[k] = SqW'(m_a_q[k]) * SqW'(m_a_q[k]);
    end
  end

  // stage c: coefficient times square as two half-width partial products
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      plo_c_d[k] = PartProdW'(coef[k][HalfW-1:0]) * PartProdW'(sq_b_q[k]);
      phi_c_d[k] = PartProdW'(coef[k][CoefW-1:HalfW]) * PartProdW'(sq_b_q[k]);
    end
  end

  // stage d: join partial products and cap each term at the table size
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      full[k]     = (ProdW'(phi_c_q[k]) << HalfW) + ProdW'(plo_c_q[k]);
      term_d_d[k] = (full[k] > CapLim) ? CapW'(CapLim) : full[k][CapW-1:0];
    end
  end

  // stage e: sum of the three terms
  assign pos_e_d = PosW'(term_d_q[0]) + PosW'(term_d_q[1]) + PosW'(term_d_q[2]);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (en_a) v_a_q <= in_valid_i;
      if (en_b) v_b_q <= v_a_q;
      if (en_c) v_c_q <= v_b_q;
      if (en_d) v_d_q <= v_c_q;
      if (en_e) v_e_q <= v_d_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      c_a_q <= c_in;
      m_a_q <= m_a_d;
    end
    if (en_b) begin
      c_b_q  <= c_a_q;
      sq_b_q <= sq_b_d;
    end
    if (en_c) begin
      c_c_q   <= c_b_q;
      plo_c_q <= plo_c_d;
      phi_c_q <= phi_c_d;
    end
    if (en_d) begin
      c_d_q    <= c_c_q;
      term_d_q <= term_d_d;
    end
    if (en_e) begin
      c_e_q   <= c_d_q;
      pos_e_q <= pos_e_d;
    end
  end

  assign beat_o = '{valid: v_e_q, op: c_e_q.op, tidx: c_e_q.tidx, twgt: c_e_q.twgt,
                    pos: pos_e_q, re: c_e_q.re, im: c_e_q.im};

`ifndef SYNTHESIS
  // every capped term stays within the table span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_d_q |-> (ProdW'(term_d_q[0]) <= CapLim) && (ProdW'(term_d_q[1]) <= CapLim) &&
              (ProdW'(term_d_q[2]) <= CapLim))
    else $error("rlsw_pos: capped term above table span");

  // an accepted beat lands in stage a
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_a_q)
    else $error("rlsw_pos: accepted beat lost at stage a");

  // a beat not taken downstream stays in the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_e_q && !take_i) |=> (v_e_q && $stable(pos_e_q)))
    else $error("rlsw_pos: stalled beat dropped at stage e");
`endif

endmodule

/* hw/rtl/rlsw_wgt.sv */
// rlsw_wgt: weight table, interpolation and saturating scale of the bin parts
// depends on rlsw_pkg and rlsw_ram
module rlsw_wgt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rlsw_pkg::pos_beat_t        beat_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rlsw_pkg::PartW-1:0] weighted_real_o,
  output logic [rlsw_pkg::PartW-1:0] weighted_imag_o
);
  import rlsw_pkg::*;

  localparam int PaW  = WgtW + FracW;
  localparam int SumW = PaW + 1;
  localparam int MulW = PartW + WgtW + 1;
  localparam int QW   = MulW + 1;
  localparam int RW   = QW - 16;
  localparam logic signed [RW-1:0] SatHi = RW'((64'sd1 <<< (SatBits - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SatLo = -SatHi - RW'(1);

  logic en_f, en_g1, en_g2, en_h, en_i;
  logic v_f_q, v_g1_q, v_g2_q, v_h_q, v_i_q;

  // table address and write decode
  logic [IntW-1:0]   int_part;
  logic              over;
  logic [TiW-1:0]    ti, half_ti;
  logic [FracW-1:0]  frac;
  logic [EvenAw-1:0] rd_addr_even, wr_addr_even;
  logic [OddAw-1:0]  rd_addr_odd, wr_addr_odd;
  logic [TidxW-1:0]  half_idx;
  logic              is_load, is_weigh, wr_ok, rd_en, we_even, we_odd;
  logic [WgtW-1:0]   even_q, odd_q;

  logic [FracW-1:0]        frac_f_q;
  logic                    sel_f_q;
  logic signed [PartW-1:0] re_f_q, im_f_q, re_g1_q, im_g1_q, re_g2_q, im_g2_q;
  logic [WgtW-1:0]         wa, wb;
  logic [PaW-1:0]          pa_g1_q, pb_g1_q;
  logic [SumW-1:0]         wsum;
  logic [WgtW-1:0]         w_g2_q;
  logic signed [WgtW:0]    w_s;
  logic signed [MulW-1:0]  pre_h_d, pim_h_d, pre_h_q, pim_h_q;
  logic [PartW-1:0]        ore_i_d, oim_i_d, ore_i_q, oim_i_q;

  // scale with round half up, floor shift and saturation
  function automatic logic [PartW-1:0] sat_round(logic signed [MulW-1:0] p);
    logic signed [QW-1:0] q;
    logic signed [RW-1:0] r;
    q = QW'(p) + QW'(RoundHalf);
    r = RW'(q >>> 16);
    if (r > SatHi) begin
      r = SatHi;
    end else if (r < SatLo) begin
      r = SatLo;
    end
    return r[PartW-1:0];
  endfunction

  // stage enables, from the output back
  assign en_i   = !v_i_q || !out_stall_i;
  assign en_h   = !v_h_q || en_i;
  assign en_g2  = !v_g2_q || en_h;
  assign en_g1  = !v_g1_q || en_g2;
  assign en_f   = !v_f_q || en_g1;
  assign take_o = en_f;

  // clamp the position and split it into entry index and fraction
  always_comb begin
    int_part = beat_i.pos[PosW-1:FracBits];
    over     = int_part >= IntW'(TableEntries);
    ti       = over ? TiW'(TableEntries - 1) : int_part[TiW-1:0];
    frac     = over ? FracW'(FracOne) : {1'b0, beat_i.pos[FracBits-1 -: 16]};
    half_ti  = ti >> 1;
    rd_addr_odd  = OddAw'(half_ti);
    rd_addr_even = EvenAw'(half_ti) + EvenAw'(ti[0]);
  end

  // loads write one bank, weigh beats read both
  always_comb begin
    is_load      = beat_i.valid && (beat_i.op == OP_LOAD);
    is_weigh     = beat_i.valid && (beat_i.op == OP_WEIGH);
    wr_ok        = beat_i.tidx <= TidxW'(TableEntries);
    half_idx     = beat_i.tidx >> 1;
    wr_addr_even = EvenAw'(half_idx);
    wr_addr_odd  = OddAw'(half_idx);
    we_even      = en_f && is_load && wr_ok && !beat_i.tidx[0];
    we_odd       = en_f && is_load && wr_ok && beat_i.tidx[0];
    rd_en        = en_f && is_weigh;
  end

  rlsw_ram #(
    .Width (WgtW),
    .Depth (EvenDepth)
  ) u_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (wr_addr_even),
    .wdata_i (beat_i.twgt),
    .re_i    (rd_en),
    .raddr_i (rd_addr_even),
    .rdata_o (even_q)
  );

  rlsw_ram #(
    .Width (WgtW),
    .Depth (OddDepth)
  ) u_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (wr_addr_odd),
    .wdata_i (beat_i.twgt),
    .re_i    (rd_en),
    .raddr_i (rd_addr_odd),
    .rdata_o (odd_q)
  );

  // stage g1: pick lower and upper entry, weight each by its share
  assign wa = sel_f_q ? odd_q : even_q;
  assign wb = sel_f_q ? even_q : odd_q;

  // stage g2: interpolated weight
  assign wsum = SumW'(pa_g1_q) + SumW'(pb_g1_q) + SumW'(RoundHalf);

  // stage h: bin parts times weight
  assign w_s     = $signed({1'b0, w_g2_q});
  assign pre_h_d = re_g2_q * w_s;
  assign pim_h_d = im_g2_q * w_s;

  // stage i: round and saturate into the output register
  assign ore_i_d = sat_round(pre_h_q);
  assign oim_i_d = sat_round(pim_h_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f_q  <= 1'b0;
      v_g1_q <= 1'b0;
      v_g2_q <= 1'b0;
      v_h_q  <= 1'b0;
      v_i_q  <= 1'b0;
    end else begin
      if (en_f)  v_f_q  <= is_weigh;
      if (en_g1) v_g1_q <= v_f_q;
      if (en_g2) v_g2_q <= v_g1_q;
      if (en_h)  v_h_q  <= v_g2_q;
      if (en_i)  v_i_q  <= v_h_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_f) begin
      frac_f_q <= frac;
      sel_f_q  <= ti[0];
      re_f_q   <= beat_i.re;
      im_f_q   <= beat_i.im;
    end
    if (en_g1) begin
      pa_g1_q <= PaW'(wa) * PaW'(FracW'(FracOne) - frac_f_q);
      pb_g1_q <= PaW'(wb) * PaW'(frac_f_q);
      re_g1_q <= re_f_q;
      im_g1_q <= im_f_q;
    end
    if (en_g2) begin
      w_g2_q  <= wsum[16 +: WgtW];
      re_g2_q <= re_g1_q;
      im_g2_q <= im_g1_q;
    end
    if (en_h) begin
      pre_h_q <= pre_h_d;
      pim_h_q <= pim_h_d;
    end
    if (en_i) begin
      ore_i_q <= ore_i_d;
      oim_i_q <= oim_i_d;
    end
  end

  assign out_valid_o     = v_i_q;
  assign weighted_real_o = ore_i_q;
  assign weighted_imag_o = oim_i_q;

`ifndef SYNTHESIS
  // a table write and a table read never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && (we_even || we_odd)))
    else $error("rlsw_wgt: table read and write in one cycle");

  // the fraction never exceeds one full unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_f_q |-> (frac_f_q <= FracW'(FracOne)))
    else $error("rlsw_wgt: interpolation fraction out of range");

  // a weigh beat taken from the position pipe reaches the table stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_weigh && take_o) |=> v_f_q)
    else $error("rlsw_wgt: weigh beat lost at table stage");
`endif

endmodule

/* hw/rtl/radial_lut_spectral_weight.sv */
// radial_lut_spectral_weight: top level, configuration registers and the two pipe sections
// depends on rlsw_pkg, rlsw_pos, rlsw_wgt (and rlsw_ram below it)
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------------------
//   in      | in_valid_i / in_stall_o   | operation, table index/weight, z/y/x, bin re/im
//   out     | out_valid_o / out_stall_i | weighted_real_o, weighted_imag_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one beat is accepted per cycle while in_stall_o is low; ten register stages. A weigh beat
// gives a result; a load writes the table as it leaves the last position stage and gives no
// result. The table is two banks (even and odd entries), each with a write and a read port,
// so both neighbours are read in one cycle. Reset clears valid bits and sets configuration
// (sizes one, coefficients zero) only; the table is undefined until loaded. A stall holds
// only full stages: empty stages keep filling, so input is taken while a result waits at the output.
module radial_lut_spectral_weight (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlsw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rlsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [rlsw_pkg::TidxW-1:0]    table_index_i,
  input  logic [rlsw_pkg::WgtW-1:0]     table_weight_i,
  input  logic [rlsw_pkg::IdxW-1:0]     z_index_i,
  input  logic [rlsw_pkg::IdxW-1:0]     y_index_i,
  input  logic [rlsw_pkg::IdxW-1:0]     x_index_i,
  input  logic [rlsw_pkg::PartW-1:0]    bin_real_i,
  input  logic [rlsw_pkg::PartW-1:0]    bin_imag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rlsw_pkg::PartW-1:0]    weighted_real_o,
  output logic [rlsw_pkg::PartW-1:0]    weighted_imag_o
);
  import rlsw_pkg::*;

  cfg_t      cfg_q;
  pos_beat_t beat;
  logic      take;

  assign cfg_ready_o = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_z <= SizeW'(1);
      cfg_q.size_y <= SizeW'(1);
      cfg_q.size_x <= SizeW'(1);
      cfg_q.coef_z <= '0;
      cfg_q.coef_y <= '0;
      cfg_q.coef_x <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SIZE_Z: cfg_q.size_z <= cfg_data_i[SizeW-1:0];
        CFG_SIZE_Y: cfg_q.size_y <= cfg_data_i[SizeW-1:0];
        CFG_SIZE_X: cfg_q.size_x <= cfg_data_i[SizeW-1:0];
        CFG_COEF_Z: cfg_q.coef_z <= cfg_data_i[CoefW-1:0];
        CFG_COEF_Y: cfg_q.coef_y <= cfg_data_i[CoefW-1:0];
        CFG_COEF_X: cfg_q.coef_x <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // fold, square, scale and sum into a table position
  rlsw_pos u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .table_index_i  (table_index_i),
    .table_weight_i (table_weight_i),
    .z_index_i      (z_index_i),
    .y_index_i      (y_index_i),
    .x_index_i      (x_index_i),
    .bin_real_i     (bin_real_i),
    .bin_imag_i     (bin_imag_i),
    .beat_o         (beat),
    .take_i         (take)
  );

  // table access, interpolation and weighting
  rlsw_wgt u_wgt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .weighted_real_o (weighted_real_o),
    .weighted_imag_o (weighted_imag_o)
  );

endmodule

/* bench/radial_lut_spectral_weight_test.sv */
`timescale 1ns / 1ps
// radial_lut_spectral_weight_test: self-checking bench for the radial weight block
// table fill, a directed stimulus table, then random phases; depends on rlsw_pkg and the rtl
module radial_lut_spectral_weight_test;
  import rlsw_pkg::*;

  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned Phases      = 8;
  localparam int unsigned PhaseBeats  = 200;
  localparam int unsigned TidxTop     = (1 << TidxW) - 1;
  localparam int unsigned SizeTop     = (1 << SizeW) - 1;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;
  localparam logic [CoefW-1:0]   CoefTop  = {CoefW{1'b1}};
  localparam logic [CoefW-1:0]   CoefUnit = 40'h01_0000_0000;
  localparam logic [CoefW-1:0]   CoefHalf = 40'h00_8000_0000;
  localparam logic [63:0]        TermCap  = 64'(TableEntries) << FracBits;
  localparam cfg_reg_e SizeReg [Axes] = '{CFG_SIZE_Z, CFG_SIZE_Y, CFG_SIZE_X};
  localparam cfg_reg_e CoefReg [Axes] = '{CFG_COEF_Z, CFG_COEF_Y, CFG_COEF_X};

  typedef struct packed {
    op_e              op;
    logic [TidxW-1:0] tidx;
    logic [WgtW-1:0]  twgt;
    logic [IdxW-1:0]  z;
    logic [IdxW-1:0]  y;
    logic [IdxW-1:0]  x;
    logic [PartW-1:0] re;
    logic [PartW-1:0] im;
  } bin_beat_t;

  typedef struct packed {
    logic [PartW-1:0] re;
    logic [PartW-1:0] im;
  } weighted_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    bin_beat_t            beat;
    logic [CfgIdxW-1:0]   cfg_idx;
    logic [CfgDataW-1:0]  cfg_data;
    bit                   typed;
    weighted_t            want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 operation_i;
  logic [TidxW-1:0]     table_index_i;
  logic [WgtW-1:0]      table_weight_i;
  logic [IdxW-1:0]      z_index_i;
  logic [IdxW-1:0]      y_index_i;
  logic [IdxW-1:0]      x_index_i;
  logic [PartW-1:0]     bin_real_i;
  logic [PartW-1:0]     bin_imag_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PartW-1:0]     weighted_real_o;
  logic [PartW-1:0]     weighted_imag_o;

  // shadow of the block: registers, weight table, results in flight
  logic [SizeW-1:0] axis_len [Axes];
  logic [CoefW-1:0] axis_coef [Axes];
  logic [WgtW-1:0]  weight_copy [0:TableEntries];
  weighted_t        weighted_due [$];
  plan_row_t        plan [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned out_run_left = 0;
  bit          input_calm = 1'b0;

  radial_lut_spectral_weight dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .table_index_i   (table_index_i),
    .table_weight_i  (table_weight_i),
    .z_index_i       (z_index_i),
    .y_index_i       (y_index_i),
    .x_index_i       (x_index_i),
    .bin_real_i      (bin_real_i),
    .bin_imag_i      (bin_imag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .weighted_real_o (weighted_real_o),
    .weighted_imag_o (weighted_imag_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[radial_lut_spectral_weight] ERROR");
      $finish;
    end
  end

  // output stall: short bursts, a few long ones, long free stretches now and then
  always @(negedge clk_i) begin
    if (out_run_left == 0) begin
      if (out_stall_i) begin
        out_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 8);
      end else begin
        out_run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
      end
      out_stall_i <= !out_stall_i;
    end else begin
      out_run_left = out_run_left - 1;
    end
  end

  task automatic note_mismatch(string msg);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // squared frequency of one axis after folding against its padded length
  function automatic logic [63:0] fold_square(logic [IdxW-1:0] i, logic [SizeW-1:0] len);
    logic [63:0] n;
    logic [63:0] m;
    n = (len > MaxAxis) ? 64'(MaxAxis) : 64'(len);
    m = 64'(i);
    if (m > (n >> 1)) m = (m >= n) ? m - n : n - m;
    return m * m;
  endfunction

  function automatic logic [63:0] axis_term(logic [CoefW-1:0] coef, logic [63:0] sq);
    logic [63:0] p;
    p = 64'(coef) * sq;
    return (p > TermCap) ? TermCap : p;
  endfunction

  // part times UQ4.16 weight, round half up, saturate
  function automatic logic [PartW-1:0] scale_part(logic [PartW-1:0] part,
                                                  logic [WgtW-1:0] w);
    longint q;
    longint r;
    longint hi;
    hi = (longint'(1) << (SatBits - 1)) - 1;
    q = longint'($signed(part)) * longint'({44'd0, w}) + RoundHalf;
    r = q >>> 16;
    if (r > hi) r = hi;
    else if (r < -hi - 1) r = -hi - 1;
    return r[PartW-1:0];
  endfunction

  // expected weighted bin from the shadow registers and table
  function automatic weighted_t weighted_bin(bin_beat_t b);
    logic [63:0] pos;
    logic [63:0] ti;
    logic [63:0] frac;
    logic [63:0] wgt;
    weighted_t   r;
    pos = axis_term(axis_coef[0], fold_square(b.z, axis_len[0]))
        + axis_term(axis_coef[1], fold_square(b.y, axis_len[1]))
        + axis_term(axis_coef[2], 64'(b.x) * 64'(b.x));
    ti   = pos >> FracBits;
    frac = (pos >> 16) & 64'hFFFF;
    // past the table end the weight is the last entry
    if (ti >= TableEntries) begin
      ti   = TableEntries - 1;
      frac = FracOne;
    end
    wgt = (64'(weight_copy[ti]) * (FracOne - frac) + 64'(weight_copy[ti + 1]) * frac
           + RoundHalf) >> 16;
    r.re = scale_part(b.re, wgt[WgtW-1:0]);
    r.im = scale_part(b.im, wgt[WgtW-1:0]);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin : watch_results
    weighted_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (weighted_due.size() == 0) begin
        note_mismatch($sformatf("result with none due: re %0d im %0d",
                                $signed(weighted_real_o), $signed(weighted_imag_o)));
      end else begin
        want = weighted_due.pop_front();
        if (weighted_real_o !== want.re)
          note_mismatch($sformatf("weighted_real %0d, want %0d",
                                  $signed(weighted_real_o), $signed(want.re)));
        if (weighted_imag_o !== want.im)
          note_mismatch($sformatf("weighted_imag %0d, want %0d",
                                  $signed(weighted_imag_o), $signed(want.im)));
      end
    end
  end

  function automatic logic [WgtW-1:0] pick_weight();
    return ($urandom_range(0, 3) == 0) ? WgtW'($urandom) : WgtW'($urandom_range(0, FracOne));
  endfunction

  function automatic logic [IdxW-1:0] pick_index();
    return ($urandom_range(0, 3) == 0) ? IdxW'($urandom_range(0, 15))
                                       : IdxW'($urandom_range(0, 1023));
  endfunction

  function automatic logic [PartW-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return PartW'(int'($urandom_range(0, 31)) - 16);
      default: return PartW'($urandom);
    endcase
  endfunction

  // weigh beat with random content everywhere, ignored fields too
  function automatic bin_beat_t rand_bin();
    bin_beat_t b;
    b.op   = OP_WEIGH;
    b.tidx = TidxW'($urandom);
    b.twgt = WgtW'($urandom);
    b.z    = pick_index();
    b.y    = pick_index();
    b.x    = pick_index();
    b.re   = pick_part();
    b.im   = pick_part();
    return b;
  endfunction

  // mostly bins, some loads near the table ends, a few out of range
  function automatic bin_beat_t random_item();
    bin_beat_t   b;
    int unsigned r;
    b = rand_bin();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      b.op   = OP_LOAD;
      b.twgt = pick_weight();
      if (r < 2) b.tidx = TidxW'($urandom_range(TableEntries + 1, TidxTop));
      else if (r < 6) b.tidx = $urandom_range(0, 1) ? TidxW'($urandom_range(0, 3))
                                                   : TidxW'($urandom_range(TableEntries - 1,
                                                                           TableEntries));
      else b.tidx = TidxW'($urandom_range(0, TableEntries));
    end
    return b;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (input_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // one input beat; the shadow is updated when the beat is taken
  task automatic send_beat(bin_beat_t b, bit typed, weighted_t want);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i    = b.op;
    table_index_i  = b.tidx;
    table_weight_i = b.twgt;
    z_index_i      = b.z;
    y_index_i      = b.y;
    x_index_i      = b.x;
    bin_real_i     = b.re;
    bin_imag_i     = b.im;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (b.op == OP_LOAD) begin
      if (b.tidx <= TableEntries) weight_copy[b.tidx] = b.twgt;
    end else begin
      weighted_due.push_back(typed ? want : weighted_bin(b));
    end
  endtask

  // drop valid, wait for every result, then let loads drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (weighted_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIZE_Z: axis_len[0] = data[SizeW-1:0];
      CFG_SIZE_Y: axis_len[1] = data[SizeW-1:0];
      CFG_SIZE_X: axis_len[2] = data[SizeW-1:0];
      CFG_COEF_Z: axis_coef[0] = data[CoefW-1:0];
      CFG_COEF_Y: axis_coef[1] = data[CoefW-1:0];
      CFG_COEF_X: axis_coef[2] = data[CoefW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stimulus table rows
  task automatic load_row(int unsigned idx, logic [WgtW-1:0] w);
    plan_row_t row;
    row = '{kind: ROW_BEAT, beat: rand_bin(), cfg_idx: '0, cfg_data: '0, typed: 1'b0,
            want: '0};
    row.beat.op   = OP_LOAD;
    row.beat.tidx = TidxW'(idx);
    row.beat.twgt = w;
    plan.push_back(row);
  endtask

  task automatic exp_row(logic [PartW-1:0] re, logic [PartW-1:0] im,
                         logic [PartW-1:0] want_re, logic [PartW-1:0] want_im);
    plan_row_t row;
    row = '{kind: ROW_BEAT, beat: rand_bin(), cfg_idx: '0, cfg_data: '0, typed: 1'b1,
            want: '{re: want_re, im: want_im}};
    row.beat.re = re;
    row.beat.im = im;
    plan.push_back(row);
  endtask

  task automatic bin_row(int unsigned z, int unsigned y, int unsigned x);
    plan_row_t row;
    row = '{kind: ROW_BEAT, beat: rand_bin(), cfg_idx: '0, cfg_data: '0, typed: 1'b0,
            want: '0};
    row.beat.z = IdxW'(z);
    row.beat.y = IdxW'(y);
    row.beat.x = IdxW'(x);
    plan.push_back(row);
  endtask

  task automatic cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, beat: '0, cfg_idx: idx, cfg_data: data, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SizeW'(1);
      2: return SizeW'(MaxAxis);
      3: return SizeW'($urandom_range(MaxAxis + 1, SizeTop));
      default: return SizeW'($urandom_range(2, MaxAxis));
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CoefTop;
      2: return CoefW'($urandom_range(0, 1 << 24));
      3: return CoefW'($urandom_range(0, 1 << 20));
      4: return CoefW'($urandom & 32'h0FFF_FFFF);
      default: return CoefW'({$urandom, $urandom});
    endcase
  endfunction

  // registers for one random phase: first two at the extremes
  task automatic configure_phase(int unsigned phase);
    logic [CfgDataW-1:0] data;
    if (phase == 2) write_reg(CfgSpare, CfgDataW'({$urandom, $urandom}));
    for (int a = 0; a < Axes; a++) begin
      data = $urandom_range(0, 1) ? CfgDataW'({$urandom, $urandom}) : '0;
      data[SizeW-1:0] = (phase == 0) ? '0 : (phase == 1) ? SizeW'(SizeTop) : pick_size();
      write_reg(SizeReg[a], data);
      data = (phase == 0) ? '0 : (phase == 1) ? CoefTop : pick_coef();
      write_reg(CoefReg[a], data);
    end
  endtask

  initial begin : stimulus
    bin_beat_t b;
    for (int a = 0; a < Axes; a++) begin
      axis_len[a]  = SizeW'(1);
      axis_coef[a] = '0;
    end
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = 1'b0;
    table_index_i  = '0;
    table_weight_i = '0;
    z_index_i      = '0;
    y_index_i      = '0;
    x_index_i      = '0;
    bin_real_i     = '0;
    bin_imag_i     = '0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every entry so no bin ever reads an unwritten one
    for (int i = 0; i <= TableEntries; i++) begin
      b      = rand_bin();
      b.op   = OP_LOAD;
      b.tidx = TidxW'(i);
      b.twgt = pick_weight();
      send_beat(b, 1'b0, '0);
    end

    // reset registers: every position is zero, the weight is entry zero
    load_row(0, 20'h1_0000);
    exp_row(12345, -12345, 12345, -12345);
    exp_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    load_row(0, 20'hF_FFFF);
    exp_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    exp_row(1, -1, 16, -16);
    load_row(0, 20'h0_0000);
    exp_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    load_row(0, 20'h0_8000);
    // halves round upward
    exp_row(3, -3, 2, -1);
    exp_row(1, -1, 1, 0);
    // loads past the table are dropped
    load_row(TableEntries + 1, 20'h1_2345);
    load_row(TidxTop, 20'hF_FFFF);
    exp_row(4, -4, 2, -2);
    load_row(TableEntries, 20'h0_C000);
    // folding, oversize length, index past its length, unfolded x
    cfg_row(CFG_SIZE_Z, CfgDataW'(SizeTop));
    cfg_row(CFG_SIZE_Y, CfgDataW'(6));
    cfg_row(CFG_SIZE_X, CfgDataW'(3));
    cfg_row(CFG_COEF_Z, CoefUnit);
    cfg_row(CFG_COEF_Y, CoefUnit);
    cfg_row(CFG_COEF_X, CoefUnit);
    bin_row(1000, 0, 0);
    bin_row(0, 3, 0);
    bin_row(0, 900, 0);
    bin_row(0, 0, 40);
    // zero length never folds
    cfg_row(CFG_SIZE_Y, '0);
    bin_row(0, 50, 0);
    // half a step lands between entries zero and one
    cfg_row(CFG_COEF_Z, CoefHalf);
    bin_row(1, 0, 0);
    // y and x terms capped, far past the table
    cfg_row(CFG_COEF_X, CoefTop);
    bin_row(1023, 1023, 1023);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle();
        write_reg(plan[k].cfg_idx, plan[k].cfg_data);
      end else begin
        send_beat(plan[k].beat, plan[k].typed, plan[k].want);
      end
    end

    // random phases, registers changed only while idle
    for (int unsigned p = 0; p < Phases; p++) begin
      settle();
      configure_phase(p);
      input_calm = ($urandom_range(0, 3) == 0);
      repeat (PhaseBeats) send_beat(random_item(), 1'b0, '0);
    end

    settle();
    if (weighted_due.size() != 0)
      note_mismatch($sformatf("%0d results never came", weighted_due.size()));
    if (mismatches == 0) begin
      $display("[radial_lut_spectral_weight] OK");
    end else begin
      $display("[radial_lut_spectral_weight] ERROR");
    end
    $finish;
  end

endmodule
